FILE: src/frlh_pkg.sv
package frlh_pkg;

    localparam int ENTRY_WIDTH  = 64;
    localparam int FRAME_WIDTH  = 55;
    localparam int COUNT_WIDTH  = 40;
    localparam int NUM_BUCKETS  = 11;
    localparam int BUCKET_WIDTH = $clog2(NUM_BUCKETS + 1);
    localparam int INDEX_WIDTH  = $clog2(NUM_BUCKETS);

    typedef logic [ENTRY_WIDTH-1:0]  entry_t;
    typedef logic [FRAME_WIDTH-1:0]  frame_t;
    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [BUCKET_WIDTH-1:0] bucket_t;
    typedef logic [INDEX_WIDTH-1:0]  index_t;

    // closed_bucket code when no run closed
    localparam bucket_t NO_BUCKET = BUCKET_WIDTH'(NUM_BUCKETS);

    typedef struct packed {
        logic    page_present;
        logic    joined_run;
        count_t  run_length;
        count_t  contiguous_pages;
        count_t  total_pages;
        count_t  largest_run;
        count_t  closed_runs;
        count_t  closed_length_sum;
        bucket_t closed_bucket;
        count_t  bucket_count;
    } result_t;

    function automatic count_t sat_inc(count_t v);
        return (&v) ? v : v + count_t'(1);
    endfunction

    function automatic count_t sat_add(count_t a, count_t b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    // floor(log2(r)), last bucket takes everything longer
    function automatic index_t bucket_of(count_t r);
        index_t idx;
        idx = '0;
        for (int i = 1; i < COUNT_WIDTH; i++)
        begin
            if (r[i])
            begin
                idx = (i >= NUM_BUCKETS - 1) ? INDEX_WIDTH'(NUM_BUCKETS - 1)
                                             : INDEX_WIDTH'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/frame_run_length_histogram_top.sv
// Channel  | Handshake                   | Word
// ---------+-----------------------------+----------------------------------------
// entry    | entry_valid / entry_ready   | entry[63:0], frame number in bits 54:0
// result   | result_valid / result_ready | page_present .. bucket_count
//
// One word in, one word out. A word passes the input register, then
// the update logic loads the result register and the run state together.
// Sustained rate is one word per cycle unless the result side stalls, with
// a combinational run state update (adjacency compare, saturating adds, bucket select).
// Reset clears the run state and the histogram at once; no clearing pass.
// A stalled result register holds the update; the input register still
// takes a word when the result is drained in the same cycle.
module frame_run_length_histogram_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    entry_valid,
    output logic                    entry_ready,
    input  frlh_pkg::entry_t        entry,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic                    page_present,
    output logic                    joined_run,
    output frlh_pkg::count_t        run_length,
    output frlh_pkg::count_t        contiguous_pages,
    output frlh_pkg::count_t        total_pages,
    output frlh_pkg::count_t        largest_run,
    output frlh_pkg::count_t        closed_runs,
    output frlh_pkg::count_t        closed_length_sum,
    output frlh_pkg::bucket_t       closed_bucket,
    output frlh_pkg::count_t        bucket_count
);
    import frlh_pkg::*;

    logic    held_valid;
    entry_t  held_entry;
    logic    space;
    logic    fire;
    result_t next_res;
    result_t held_res;

    // a held word moves on when the result register is free or draining
    assign fire = held_valid && space;

    frlh_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready),
        .entry       (entry),
        .fire        (fire),
        .held_valid  (held_valid),
        .held_entry  (held_entry)
    );

    frlh_update u_update (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .entry (held_entry),
        .res   (next_res)
    );

    frlh_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .res          (next_res),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .held         (held_res)
    );

    assign page_present      = held_res.page_present;
    assign joined_run        = held_res.joined_run;
    assign run_length        = held_res.run_length;
    assign contiguous_pages  = held_res.contiguous_pages;
    assign total_pages       = held_res.total_pages;
    assign largest_run       = held_res.largest_run;
    assign closed_runs       = held_res.closed_runs;
    assign closed_length_sum = held_res.closed_length_sum;
    assign closed_bucket     = held_res.closed_bucket;
    assign bucket_count      = held_res.bucket_count;

    // a closed run restarts at length one and reports a nonzero bucket count
    a_close_restart: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (closed_bucket != NO_BUCKET) |->
            page_present && !joined_run && (run_length == count_t'(1))
            && (bucket_count != '0))
        else $error("closed run result inconsistent");

    // a skipped or joined word never touches the histogram
    a_no_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (!page_present || joined_run) |->
            (closed_bucket == NO_BUCKET) && (bucket_count == '0))
        else $error("histogram updated without a closed run");

    // a word taken into the result register with no new entry offered leaves the input side free
    a_fire_frees: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !entry_valid |=> !held_valid && result_valid)
        else $error("pipeline lost track of a word");

endmodule

FILE: src/frlh_in_stage.sv
module frlh_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             entry_valid,
    output logic             entry_ready,
    input  frlh_pkg::entry_t entry,
    input  logic             fire,
    output logic             held_valid,
    output frlh_pkg::entry_t held_entry
);
    import frlh_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;

    assign entry_ready = !valid_reg || fire;
    assign valid_next  = (entry_valid && entry_ready) ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (entry_valid && entry_ready)
            entry_reg <= entry;
    end

    assign held_valid = valid_reg;
    assign held_entry = entry_reg;

endmodule

FILE: src/frlh_update.sv
module frlh_update (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  frlh_pkg::entry_t  entry,
    output frlh_pkg::result_t res
);
    import frlh_pkg::*;

    frame_t prev_frame_reg;
    count_t open_run_reg;
    count_t joined_count_reg;
    count_t page_count_reg;
    count_t longest_run_reg;
    count_t run_count_reg;
    count_t run_sum_reg;
    count_t hist_reg [NUM_BUCKETS];

    frame_t prev_frame_next;
    count_t open_run_next;
    count_t joined_count_next;
    count_t page_count_next;
    count_t longest_run_next;
    count_t run_count_next;
    count_t run_sum_next;
    count_t hist_inc;

    frame_t frame;
    logic   present;
    logic   adjacent;
    logic   closing;
    index_t idx;

    assign frame   = entry[FRAME_WIDTH-1:0];
    assign present = |frame;
    // one below counts only when the previous frame is nonzero; no wrap
    assign adjacent = (frame == prev_frame_reg)
                   || ({1'b0, frame} == ({1'b0, prev_frame_reg} + (FRAME_WIDTH+1)'(1)))
                   || ((|prev_frame_reg) && (frame == prev_frame_reg - frame_t'(1)));
    assign closing  = present && !adjacent;
    assign idx      = bucket_of(open_run_reg);
    assign hist_inc = sat_inc(hist_reg[idx]);

    always_comb
    begin
        prev_frame_next   = prev_frame_reg;
        open_run_next     = open_run_reg;
        joined_count_next = joined_count_reg;
        page_count_next   = page_count_reg;
        longest_run_next  = longest_run_reg;
        run_count_next    = run_count_reg;
        run_sum_next      = run_sum_reg;
        if (present)
        begin
            prev_frame_next = frame;
            page_count_next = sat_inc(page_count_reg);
            if (adjacent)
            begin
                joined_count_next = sat_inc(joined_count_reg);
                open_run_next     = sat_inc(open_run_reg);
            end
            else
            begin
                if (open_run_reg > longest_run_reg)
                    longest_run_next = open_run_reg;
                run_count_next = sat_inc(run_count_reg);
                run_sum_next   = sat_add(run_sum_reg, open_run_reg);
                open_run_next  = count_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_frame_reg   <= '0;
            open_run_reg     <= count_t'(1);
            joined_count_reg <= '0;
            page_count_reg   <= '0;
            longest_run_reg  <= '0;
            run_count_reg    <= '0;
            run_sum_reg      <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++)
                hist_reg[i] <= '0;
        end
        else if (fire)
        begin
            prev_frame_reg   <= prev_frame_next;
            open_run_reg     <= open_run_next;
            joined_count_reg <= joined_count_next;
            page_count_reg   <= page_count_next;
            longest_run_reg  <= longest_run_next;
            run_count_reg    <= run_count_next;
            run_sum_reg      <= run_sum_next;
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                if (closing && (idx == INDEX_WIDTH'(i)))
                    hist_reg[i] <= hist_inc;
            end
        end
    end

    always_comb
    begin
        res.page_present      = present;
        res.joined_run        = present && adjacent;
        res.run_length        = open_run_next;
        res.contiguous_pages  = joined_count_next;
        res.total_pages       = page_count_next;
        res.largest_run       = longest_run_next;
        res.closed_runs       = run_count_next;
        res.closed_length_sum = run_sum_next;
        res.closed_bucket     = closing ? BUCKET_WIDTH'(idx) : NO_BUCKET;
        res.bucket_count      = closing ? hist_inc : '0;
    end

endmodule

FILE: src/frlh_out_stage.sv
module frlh_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  frlh_pkg::result_t res,
    output logic              space,
    output logic              result_valid,
    input  logic              result_ready,
    output frlh_pkg::result_t held
);
    import frlh_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || result_ready;
    assign valid_next = load ? 1'b1 : (result_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign result_valid = valid_reg;
    assign held         = res_reg;

endmodule

FILE: sim/run_histogram_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each result word from the accepted entry
// words and compares field by field.
module run_histogram_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                entry_valid,
    input  logic                entry_ready,
    input  frlh_pkg::entry_t    entry,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic                page_present,
    input  logic                joined_run,
    input  frlh_pkg::count_t    run_length,
    input  frlh_pkg::count_t    contiguous_pages,
    input  frlh_pkg::count_t    total_pages,
    input  frlh_pkg::count_t    largest_run,
    input  frlh_pkg::count_t    closed_runs,
    input  frlh_pkg::count_t    closed_length_sum,
    input  frlh_pkg::bucket_t   closed_bucket,
    input  frlh_pkg::count_t    bucket_count,
    output int                  fault_count,
    output int                  pending
);
    import frlh_pkg::*;

    localparam count_t COUNT_TOP = '1;

    // predicted run state
    frame_t  last_frame;
    count_t  cur_run;
    count_t  joined_pages;
    count_t  seen_pages;
    count_t  best_run;
    count_t  runs_closed;
    count_t  runs_sum;
    count_t  hist [NUM_BUCKETS];

    result_t expected_runs [$];
    result_t want_word;
    result_t next_word;
    int      faults;

    function automatic count_t bump(count_t v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            faults++;
        end
    endtask

    task automatic advance_runs(input entry_t w, output result_t r);
        frame_t f;
        logic   adj;
        int     idx;
        count_t v;
        f = w[FRAME_WIDTH-1:0];
        r = '0;
        r.closed_bucket = NO_BUCKET;
        if (f != '0)
        begin
            adj = (f == last_frame) ||
                  ({1'b0, f} == {1'b0, last_frame} + 1'b1) ||
                  (last_frame != '0 && f == last_frame - 1'b1);
            r.page_present = 1'b1;
            if (adj)
            begin
                r.joined_run = 1'b1;
                joined_pages = bump(joined_pages);
                cur_run = bump(cur_run);
            end
            else
            begin
                // floor(log2), top bucket catches the rest
                idx = 0;
                v = cur_run;
                while (v > 1 && idx < NUM_BUCKETS - 1)
                begin
                    v = v >> 1;
                    idx++;
                end
                if (cur_run > best_run)
                    best_run = cur_run;
                runs_closed = bump(runs_closed);
                runs_sum = (cur_run > COUNT_TOP - runs_sum) ? COUNT_TOP : runs_sum + cur_run;
                hist[idx] = bump(hist[idx]);
                r.closed_bucket = bucket_t'(idx);
                r.bucket_count = hist[idx];
                cur_run = count_t'(1);
            end
            last_frame = f;
            seen_pages = bump(seen_pages);
        end
        r.run_length        = cur_run;
        r.contiguous_pages  = joined_pages;
        r.total_pages       = seen_pages;
        r.largest_run       = best_run;
        r.closed_runs       = runs_closed;
        r.closed_length_sum = runs_sum;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame   = '0;
            cur_run      = count_t'(1);
            joined_pages = '0;
            seen_pages   = '0;
            best_run     = '0;
            runs_closed  = '0;
            runs_sum     = '0;
            for (int i = 0; i < NUM_BUCKETS; i++)
                hist[i] = '0;
            expected_runs.delete();
            faults = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $time);
                    faults++;
                end
                else
                begin
                    want_word = expected_runs.pop_front();
                    check_field("page_present", want_word.page_present, page_present);
                    check_field("joined_run", want_word.joined_run, joined_run);
                    check_field("run_length", want_word.run_length, run_length);
                    check_field("contiguous_pages", want_word.contiguous_pages,
                                contiguous_pages);
                    check_field("total_pages", want_word.total_pages, total_pages);
                    check_field("largest_run", want_word.largest_run, largest_run);
                    check_field("closed_runs", want_word.closed_runs, closed_runs);
                    check_field("closed_length_sum", want_word.closed_length_sum,
                                closed_length_sum);
                    check_field("closed_bucket", want_word.closed_bucket, closed_bucket);
                    check_field("bucket_count", want_word.bucket_count, bucket_count);
                end
            end
            if (entry_valid && entry_ready)
            begin
                advance_runs(entry, next_word);
                expected_runs = {expected_runs, next_word};
            end
        end
        fault_count <= faults;
        pending     <= expected_runs.size();
    end

endmodule

FILE: sim/frame_run_length_histogram_top_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the run length histogram block. The checker
// beside the block does all prediction and comparison.
module frame_run_length_histogram_top_test;
    import frlh_pkg::*;

    localparam int     CLK_HIGH     = 6;
    localparam int     CLK_LOW      = 6;
    localparam int     HOLD_CYCLES  = 60;    // long receiver hold-off
    localparam int     STUCK_LIMIT  = 2000;  // cycles with no word moving
    localparam int     DRAIN_CYCLES = 8;     // drain margin after the last expected word
    localparam frame_t FRAME_MAX    = '1;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     entry_valid  = 1'b0;
    entry_t   entry        = '0;
    logic     result_ready = 1'b0;
    logic     entry_ready;
    logic     result_valid;
    logic     page_present;
    logic     joined_run;
    count_t   run_length;
    count_t   contiguous_pages;
    count_t   total_pages;
    count_t   largest_run;
    count_t   closed_runs;
    count_t   closed_length_sum;
    bucket_t  closed_bucket;
    count_t   bucket_count;
    int       fault_count;
    int       pending;

    // idle percentages per side, changed by the stimulus phases
    int       send_idle    = 28;
    int       recv_idle    = 77;
    int       holds_asked  = 0;
    int       holds_done   = 0;
    int       words_sent   = 0;
    int       stuck_cycles = 0;
    int       hold_left;

    frame_run_length_histogram_top u_top (.*);

    run_histogram_checker u_checker (.*);

    always
    begin
        #(CLK_LOW) clk = 1'b1;
        #(CLK_HIGH) clk = 1'b0;
    end

    function automatic frame_t rand_frame();
        return frame_t'({$urandom, $urandom});
    endfunction

    // Offer one entry word after a random gap and hold it until taken.
    // Valid stays high into the next call when no gap is drawn.
    task automatic send_word(input entry_t w);
        while ($urandom_range(99) < send_idle)
        begin
            entry_valid <= 1'b0;
            @(posedge clk);
        end
        entry_valid <= 1'b1;
        entry       <= w;
        @(posedge clk);
        while (!entry_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Frame with random flag bits above it; flags must not matter.
    task automatic send_frame(input frame_t f);
        entry_t w;
        w = {$urandom, $urandom};
        w[FRAME_WIDTH-1:0] = f;
        send_word(w);
    endtask

    // A random walk of adjacent frames: each step is -1, 0 or +1, with the
    // odd skipped (frame zero) word mixed in, which must not break the run.
    task automatic send_run(input frame_t start, input int len);
        frame_t f;
        int     step;
        f = start;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(19) == 0)
                send_frame('0);
            send_frame(f);
            step = $urandom_range(2);
            if (step == 0)
                f = f - 1'b1;
            else if (step == 2)
                f = f + 1'b1;
        end
    endtask

    // Mostly well-formed runs of varied length; the rest skipped words and
    // lone jumps that close runs of length one.
    task automatic random_phase(input int words);
        int          stop;
        int unsigned pick;
        int unsigned shape;
        int          len;
        frame_t      start;
        stop = words_sent + words;
        while (words_sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_frame('0);
            else if (pick < 15)
                send_frame(rand_frame());
            else
            begin
                shape = $urandom_range(99);
                if (shape < 75)
                    len = $urandom_range(12, 1);
                else if (shape < 95)
                    len = $urandom_range(40, 13);
                else
                    len = $urandom_range(200, 41);
                pick = $urandom_range(2);
                if (pick == 0)
                    start = rand_frame();
                else if (pick == 1)
                    start = frame_t'($urandom_range(64, 1));
                else
                    start = FRAME_MAX - frame_t'($urandom_range(3));
                send_run(start, len);
            end
        end
    endtask

    // Receiver: random ready per cycle, or a counted hold-off on request so
    // the block backs up and drops entry_ready.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                result_ready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge clk);
                holds_done++;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: any accepted word on either channel restarts the count.
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (entry_valid && entry_ready) || (result_valid && result_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("frame_run_length_histogram_top_test: errors");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: skipped words, first frame one joining the reset run,
        // equal / up / down neighbors, frame range extremes, closes of
        // several lengths, a skip inside a run, alternating bit patterns
        send_word('0);
        send_word(64'hFF80_0000_0000_0000);
        send_frame(frame_t'(1));
        send_frame(frame_t'(1));
        send_frame(frame_t'(2));
        send_frame(frame_t'(1));
        send_word('1);
        send_frame(FRAME_MAX - 1'b1);
        send_frame(FRAME_MAX);
        send_frame(frame_t'(3));
        send_frame(frame_t'(5));
        send_word(64'h8000_0000_0000_0000);
        send_frame(frame_t'(6));
        send_frame(frame_t'(4));
        send_frame(frame_t'(55'h2A_AAAA_AAAA_AAAA));
        send_frame(frame_t'(55'h55_5555_5555_5555));
        send_frame(frame_t'(55'h55_5555_5555_5554));

        // sender light idle, receiver heavy idle
        random_phase(150);

        // swapped
        send_idle <= 77;
        recv_idle <= 28;
        random_phase(150);

        // no idling; long hold-off on the result side first
        send_idle   <= 0;
        recv_idle   <= 0;
        holds_asked <= holds_asked + 1;
        random_phase(100);

        // long runs for the upper buckets, each closed by a jump
        send_run(rand_frame(), 520);
        send_frame(rand_frame());
        send_run(rand_frame(), 1030);
        send_frame(rand_frame());
        entry_valid <= 1'b0;

        // let the last word show up in the count before waiting on it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("frame_run_length_histogram_top_test: clean");
        else
            $display("frame_run_length_histogram_top_test: errors");
        $finish;
    end

endmodule

FILE: frame_run_length_histogram_top.f
src/frlh_pkg.sv
src/frlh_in_stage.sv
src/frlh_update.sv
src/frlh_out_stage.sv
src/frame_run_length_histogram_top.sv
sim/run_histogram_checker.sv
sim/frame_run_length_histogram_top_test.sv
